>>> design/fsn_pkg.sv
package fsn_pkg;

    // Field widths fixed by the record and result formats.
    localparam int WORD_W     = 48;
    localparam int NAME_BYTES = 24;
    localparam int KEY_W      = 4 * WORD_W;
    localparam int AGE_W      = 8;
    localparam int OUT_IDX_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_AGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AGE_HIGH = 1'b1;

    // Register reset values.
    localparam logic [AGE_W-1:0] AGE_LOW_RESET  = 8'd30;
    localparam logic [AGE_W-1:0] AGE_HIGH_RESET = 8'd40;

    typedef struct packed {
        logic [WORD_W-1:0] name_bytes_0_5;
        logic [WORD_W-1:0] name_bytes_6_11;
        logic [WORD_W-1:0] name_bytes_12_17;
        logic [WORD_W-1:0] name_bytes_18_23;
        logic [AGE_W-1:0]  age;
        logic              last_record;
    } rec_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] slot;
        logic [OUT_IDX_W-1:0] source_index;
        logic                 last_slot;
        logic                 overflow;
    } res_t;

    // Commands that every cell of the sort chain sees in the same cycle.
    typedef struct packed {
        logic insert;
        logic pop;
        logic clear;
    } cell_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // Zeroes every byte that follows the first zero byte of a name.
    function automatic logic [KEY_W-1:0] trim_name(input logic [KEY_W-1:0] name);
        logic [KEY_W-1:0] trimmed;
        logic             ended;
        trimmed = name;
        ended   = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (ended)
            begin
                trimmed[KEY_W-1-8*b -: 8] = 8'h00;
            end
            else if (name[KEY_W-1-8*b -: 8] == 8'h00)
            begin
                ended = 1'b1;
            end
        end
        return trimmed;
    endfunction

endpackage

>>> design/filtered_slot_name_sorter.sv
// Filtered slot name sorter.
// Records arrive on rec_valid/rec_ready, one transaction per cycle while the
// block is loading. A record whose age lies within the configured bounds is
// inserted into a chain of sort cells; each cell compares its stored name with
// the incoming one in the same cycle. The transaction marked last_record closes
// the set. From the next cycle the block drains one result per loaded slot on
// res_valid/res_ready, in slot order: eligible slots take the chain head in
// turn, other slots report themselves. Records beyond CAPACITY are dropped and
// flagged on every result of that set.
// The result sits in an output register; when the receiver stalls it holds
// and the drain counter waits. Loading of the next set starts as soon as the
// final result of a set is registered.
// Reset sets the age bounds to 30 and 40 and empties the set; no clearing
// pass is needed. Configuration writes on cfg_we take effect in the next cycle.
module filtered_slot_name_sorter
    import fsn_pkg::*;
#(
    parameter int CAPACITY = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  rec_valid,
    output logic                  rec_ready,
    input  rec_t                  rec,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    state_t state_reg, state_next;

    logic [AGE_W-1:0]    age_low_reg, age_high_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [CAPACITY-1:0] elig_reg, elig_next;
    logic                ovf_reg, ovf_next;
    logic [IW-1:0]       drain_reg, drain_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg, res_next;

    logic             rec_accept;
    logic             has_room;
    logic             rec_elig;
    logic [KEY_W-1:0] rec_key;
    logic             load_res;
    logic             slot_elig;
    logic             final_slot;
    logic [IW-1:0]    head_src;
    cell_ctrl_t       chain_ctrl;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_low_reg  <= AGE_LOW_RESET;
            age_high_reg <= AGE_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AGE_LOW:  age_low_reg  <= cfg_data;
                REG_AGE_HIGH: age_high_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Incoming record: trimmed key and eligibility fixed at arrival.
    assign rec_accept = rec_valid && rec_ready;
    assign has_room   = count_reg < CAP_COUNT;
    assign rec_key    = trim_name({rec.name_bytes_0_5, rec.name_bytes_6_11,
                                   rec.name_bytes_12_17, rec.name_bytes_18_23});
    assign rec_elig   = (rec.age >= age_low_reg) && (rec.age <= age_high_reg);

    // Drain step for the current slot.
    assign slot_elig  = elig_reg[drain_reg];
    assign final_slot = (CW'(drain_reg) + CW'(1)) == count_reg;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (rec_accept && rec.last_record)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (load_res && final_slot)
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // State outputs.
    always_comb
    begin
        rec_ready = 1'b0;
        load_res  = 1'b0;
        unique case (state_reg)
            ST_LOAD:  rec_ready = 1'b1;
            ST_DRAIN: load_res  = !res_valid_reg || res_ready;
            default:  ;
        endcase
    end

    // Chain commands.
    always_comb
    begin
        chain_ctrl.insert = rec_accept && has_room && rec_elig;
        chain_ctrl.pop    = load_res && slot_elig;
        chain_ctrl.clear  = load_res && final_slot;
    end

    fsn_chain #(
        .DEPTH (CAPACITY),
        .SRC_W (IW)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (chain_ctrl),
        .ins_key  (rec_key),
        .ins_src  (count_reg[IW-1:0]),
        .head_src (head_src)
    );

    // Set bookkeeping and drain counter.
    always_comb
    begin
        count_next = count_reg;
        elig_next  = elig_reg;
        ovf_next   = ovf_reg;
        drain_next = drain_reg;
        if (rec_accept)
        begin
            if (has_room)
            begin
                elig_next[count_reg[IW-1:0]] = rec_elig;
                count_next                   = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (load_res)
        begin
            if (final_slot)
            begin
                count_next = '0;
                elig_next  = '0;
                ovf_next   = 1'b0;
                drain_next = '0;
            end
            else
            begin
                drain_next = drain_reg + IW'(1);
            end
        end
    end

    // Output register.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (load_res)
        begin
            res_valid_next        = 1'b1;
            res_next.slot         = OUT_IDX_W'(drain_reg);
            res_next.source_index = slot_elig ? OUT_IDX_W'(head_src)
                                              : OUT_IDX_W'(drain_reg);
            res_next.last_slot    = final_slot;
            res_next.overflow     = ovf_reg;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            elig_reg      <= '0;
            ovf_reg       <= 1'b0;
            drain_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            elig_reg      <= elig_next;
            ovf_reg       <= ovf_next;
            drain_reg     <= drain_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> design/fsn_cell.sv
module fsn_cell
    import fsn_pkg::*;
#(
    parameter int SRC_W = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] ins_key,
    input  logic [SRC_W-1:0] ins_src,
    input  logic             left_open,
    input  logic             left_valid,
    input  logic [KEY_W-1:0] left_key,
    input  logic [SRC_W-1:0] left_src,
    input  logic             right_valid,
    input  logic [KEY_W-1:0] right_key,
    input  logic [SRC_W-1:0] right_src,
    output logic             valid,
    output logic [KEY_W-1:0] key,
    output logic [SRC_W-1:0] src,
    output logic             open
);

    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [SRC_W-1:0] src_reg, src_next;

    // A cell makes room when it is empty or holds a strictly greater name,
    // so equal names keep their arrival order.
    assign open = !valid_reg || (key_reg > ins_key);

    // Insert shifts the tail right by one, pop shifts the chain toward the head.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        src_next   = src_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.pop)
        begin
            valid_next = right_valid;
            key_next   = right_key;
            src_next   = right_src;
        end
        else if (ctrl.insert && open)
        begin
            if (left_open)
            begin
                valid_next = left_valid;
                key_next   = left_key;
                src_next   = left_src;
            end
            else
            begin
                valid_next = 1'b1;
                key_next   = ins_key;
                src_next   = ins_src;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        src_reg <= src_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign src   = src_reg;

endmodule

>>> design/fsn_chain.sv
module fsn_chain
    import fsn_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int SRC_W = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] ins_key,
    input  logic [SRC_W-1:0] ins_src,
    output logic [SRC_W-1:0] head_src
);

    logic             valid_w [DEPTH];
    logic [KEY_W-1:0] key_w   [DEPTH];
    logic [SRC_W-1:0] src_w   [DEPTH];
    logic             open_w  [DEPTH];

    // Row of cells kept in ascending name order, smallest at the head.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic             l_open;
        logic             l_valid;
        logic [KEY_W-1:0] l_key;
        logic [SRC_W-1:0] l_src;
        logic             r_valid;
        logic [KEY_W-1:0] r_key;
        logic [SRC_W-1:0] r_src;

        if (i == 0)
        begin : g_head
            assign l_open  = 1'b0;
            assign l_valid = 1'b0;
            assign l_key   = '0;
            assign l_src   = '0;
        end
        else
        begin : g_left
            assign l_open  = open_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_key   = key_w[i-1];
            assign l_src   = src_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_key   = '0;
            assign r_src   = '0;
        end
        else
        begin : g_right
            assign r_valid = valid_w[i+1];
            assign r_key   = key_w[i+1];
            assign r_src   = src_w[i+1];
        end

        fsn_cell #(
            .SRC_W (SRC_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .ins_key     (ins_key),
            .ins_src     (ins_src),
            .left_open   (l_open),
            .left_valid  (l_valid),
            .left_key    (l_key),
            .left_src    (l_src),
            .right_valid (r_valid),
            .right_key   (r_key),
            .right_src   (r_src),
            .valid       (valid_w[i]),
            .key         (key_w[i]),
            .src         (src_w[i]),
            .open        (open_w[i])
        );
    end

    assign head_src = src_w[0];

endmodule

>>> dv/tb_filtered_slot_name_sorter.sv
module tb_filtered_slot_name_sorter
    import fsn_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 8;
    localparam int DRAIN_GAP   = 2 * SLOTS + 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int BATCH_ITEMS = 28;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  rec_valid = 1'b0;
    logic                  rec_ready;
    rec_t                  rec       = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_t                  res;

    filtered_slot_name_sorter #(
        .CAPACITY (SLOTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Records waiting to be driven and slot results waiting to be seen.
    rec_t record_queue[$];
    res_t expected_slots[$];
    res_t oldest_slot;

    // Shadow of the age bounds and of the set being loaded.
    logic [AGE_W-1:0] lo_bound = AGE_LOW_RESET;
    logic [AGE_W-1:0] hi_bound = AGE_HIGH_RESET;
    logic [KEY_W-1:0] held_key[SLOTS];
    logic             held_elig[SLOTS];
    int               held_count    = 0;
    logic             held_overflow = 1'b0;

    // Traffic shaping and bookkeeping.
    int   send_idle_pct  = 30;
    int   recv_idle_pct  = 65;
    logic wait_for_drain = 1'b0;
    logic rec_taken      = 1'b0;
    int   mismatches     = 0;
    int   cycle_count    = 0;
    int   sets_closed    = 0;
    int   overflow_sets  = 0;
    int   unsorted_sets  = 0;
    int   slots_checked  = 0;
    int   items_sent     = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Zero every byte behind the first zero byte, scanning from the first byte.
    function automatic logic [KEY_W-1:0] blank_after_terminator(input logic [KEY_W-1:0] name);
        logic [KEY_W-1:0] cleaned;
        logic             seen_end;
        cleaned  = '0;
        seen_end = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (!seen_end)
            begin
                cleaned[KEY_W-1-8*b -: 8] = name[KEY_W-1-8*b -: 8];
            end
            if (name[KEY_W-1-8*b -: 8] == 8'h00)
            begin
                seen_end = 1'b1;
            end
        end
        return cleaned;
    endfunction

    // Store one accepted record and, when it closes the set, predict the slot results.
    task automatic predict_record(input rec_t r);
        int   order[SLOTS];
        int   owner[SLOTS];
        int   eligible_n;
        int   cur;
        int   j;
        res_t slot_res;
        if (held_count < SLOTS)
        begin
            held_key[held_count]  = blank_after_terminator({r.name_bytes_0_5, r.name_bytes_6_11,
                                                            r.name_bytes_12_17,
                                                            r.name_bytes_18_23});
            held_elig[held_count] = (r.age >= lo_bound) && (r.age <= hi_bound);
            held_count++;
        end
        else
        begin
            held_overflow = 1'b1;
        end
        if (r.last_record)
        begin
            eligible_n = 0;
            for (int s = 0; s < held_count; s++)
            begin
                owner[s] = s;
                if (held_elig[s])
                begin
                    order[eligible_n] = s;
                    eligible_n++;
                end
            end
            // Stable insertion sort of the eligible slots by name.
            for (int i = 1; i < eligible_n; i++)
            begin
                cur = order[i];
                j   = i;
                while (j > 0 && held_key[order[j-1]] > held_key[cur])
                begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = cur;
            end
            // The k-th eligible slot receives the k-th record in name order.
            eligible_n = 0;
            for (int s = 0; s < held_count; s++)
            begin
                if (held_elig[s])
                begin
                    owner[s] = order[eligible_n];
                    eligible_n++;
                end
            end
            for (int s = 0; s < held_count; s++)
            begin
                slot_res.slot         = s[OUT_IDX_W-1:0];
                slot_res.source_index = owner[s][OUT_IDX_W-1:0];
                slot_res.last_slot    = (s == held_count - 1);
                slot_res.overflow     = held_overflow;
                expected_slots.push_back(slot_res);
            end
            sets_closed++;
            if (held_overflow)
            begin
                overflow_sets++;
            end
            if (eligible_n == 0)
            begin
                unsorted_sets++;
            end
            held_count    = 0;
            held_overflow = 1'b0;
            for (int s = 0; s < SLOTS; s++)
            begin
                held_elig[s] = 1'b0;
            end
        end
    endtask

    // Build a name from text; bytes past the terminator are filled with tail.
    function automatic logic [KEY_W-1:0] text_name(input string s, input logic [7:0] tail);
        logic [KEY_W-1:0] name;
        name = '0;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            if (b < s.len())
            begin
                name[KEY_W-1-8*b -: 8] = s[b];
            end
            else if (b > s.len())
            begin
                name[KEY_W-1-8*b -: 8] = tail;
            end
        end
        return name;
    endfunction

    // Half of the names are short, from a tiny alphabet, so that ties and shared
    // prefixes are common; garbage is left behind the terminator.
    function automatic logic [KEY_W-1:0] random_name();
        logic [KEY_W-1:0] name;
        int               style;
        int               len;
        style = $urandom_range(0, 5);
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            name[KEY_W-1-8*b -: 8] = 8'($urandom_range(0, 255));
        end
        if (style != 5)
        begin
            len = (style < 3) ? $urandom_range(0, 4) : $urandom_range(0, NAME_BYTES);
            for (int b = 0; b < len; b++)
            begin
                name[KEY_W-1-8*b -: 8] = (style < 3) ? 8'(8'h61 + $urandom_range(0, 2))
                                                     : 8'($urandom_range(1, 255));
            end
            if (len < NAME_BYTES)
            begin
                name[KEY_W-1-8*len -: 8] = 8'h00;
            end
        end
        return name;
    endfunction

    // Ages cluster on and around the current bounds.
    function automatic logic [AGE_W-1:0] pick_age();
        case ($urandom_range(0, 4))
            0:       return lo_bound;
            1:       return hi_bound;
            2:       return lo_bound - 8'd1;
            3:       return hi_bound + 8'd1;
            default: return AGE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_rec(input logic [KEY_W-1:0] name, input logic [AGE_W-1:0] age,
                            input logic last);
        rec_t r;
        r.name_bytes_0_5   = name[KEY_W-1 -: WORD_W];
        r.name_bytes_6_11  = name[KEY_W-1-WORD_W -: WORD_W];
        r.name_bytes_12_17 = name[KEY_W-1-2*WORD_W -: WORD_W];
        r.name_bytes_18_23 = name[WORD_W-1:0];
        r.age              = age;
        r.last_record      = last;
        record_queue.push_back(r);
        items_sent++;
    endtask

    task automatic write_bound(input logic [CFG_IDX_W-1:0] index, input logic [AGE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == REG_AGE_LOW)
        begin
            lo_bound = value;
        end
        else
        begin
            hi_bound = value;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every record is taken and every slot result has come back.
    task automatic wait_idle();
        while (record_queue.size() != 0 || rec_valid || expected_slots.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // Record driver: a new transaction is offered only once the previous one is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!rec_valid || rec_taken))
        begin
            if (record_queue.size() != 0 && !(wait_for_drain && expected_slots.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                rec       <= record_queue.pop_front();
                rec_valid <= 1'b1;
            end
            else
            begin
                rec_valid <= 1'b0;
            end
        end
    end

    // Result receiver stalls at random.
    always @(negedge clk)
    begin
        res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Each accepted record transaction updates the prediction.
    always @(posedge clk)
    begin
        if (rst_n && rec_valid && rec_ready)
        begin
            predict_record(rec);
        end
        rec_taken <= rst_n && rec_valid && rec_ready;
    end

    // Each accepted result transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_slots.size() == 0)
            begin
                $error("unexpected result: slot %0d source_index %0d", res.slot, res.source_index);
                mismatches++;
            end
            else
            begin
                oldest_slot = expected_slots.pop_front();
                slots_checked++;
                if (res.slot !== oldest_slot.slot)
                begin
                    $error("slot: expected %0d, actual %0d", oldest_slot.slot, res.slot);
                    mismatches++;
                end
                if (res.source_index !== oldest_slot.source_index)
                begin
                    $error("source_index: expected %0d, actual %0d",
                           oldest_slot.source_index, res.source_index);
                    mismatches++;
                end
                if (res.last_slot !== oldest_slot.last_slot)
                begin
                    $error("last_slot: expected %0d, actual %0d",
                           oldest_slot.last_slot, res.last_slot);
                    mismatches++;
                end
                if (res.overflow !== oldest_slot.overflow)
                begin
                    $error("overflow: expected %0d, actual %0d",
                           oldest_slot.overflow, res.overflow);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("filtered_slot_name_sorter regression: fail");
            $finish;
        end
    end

    initial
    begin
        int set_len;
        int batch_count;
        logic [AGE_W-1:0] bound_a;

        for (int s = 0; s < SLOTS; s++)
        begin
            held_elig[s] = 1'b0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A set of one record.
        push_rec(text_name("solo", 8'h00), 8'd30, 1'b1);
        // Bounds are inclusive; only the two middle records trade places.
        push_rec(text_name("delta", 8'h00), 8'd29, 1'b0);
        push_rec(text_name("charlie", 8'h00), 8'd30, 1'b0);
        push_rec(text_name("bravo", 8'h00), 8'd40, 1'b0);
        push_rec(text_name("alpha", 8'h00), 8'd41, 1'b1);
        // Garbage after the terminator is ignored, equal names keep input order,
        // and a prefix sorts ahead of the longer name.
        push_rec(text_name("abc", 8'h00), 8'd35, 1'b0);
        push_rec(text_name("ab", 8'hFF), 8'd36, 1'b0);
        push_rec(text_name("ab", 8'h00), 8'd37, 1'b1);
        // A full set plus one dropped record that still closes the set.
        for (int k = 0; k < SLOTS + 1; k++)
        begin
            push_rec(random_name(), 8'd35, k == SLOTS);
        end
        // Largest name ahead of the empty name.
        push_rec({KEY_W{1'b1}}, 8'd40, 1'b0);
        push_rec('0, 8'd30, 1'b1);
        wait_idle();

        // Bounds change halfway through loading; earlier records keep their flags.
        push_rec(text_name("zz", 8'h00), 8'd50, 1'b0);
        push_rec(text_name("yy", 8'h00), 8'd50, 1'b0);
        wait_idle();
        write_bound(REG_AGE_LOW, 8'd0);
        write_bound(REG_AGE_HIGH, 8'd255);
        push_rec(text_name("xx", 8'h00), 8'd50, 1'b0);
        push_rec(text_name("ww", 8'h00), 8'd50, 1'b1);
        wait_idle();

        // Inverted bounds: nothing is eligible, every slot reports itself.
        write_bound(REG_AGE_LOW, 8'd255);
        write_bound(REG_AGE_HIGH, 8'd0);
        push_rec(text_name("b", 8'h00), 8'd255, 1'b0);
        push_rec(text_name("a", 8'h00), 8'd0, 1'b1);
        wait_idle();

        // Random sets under a sequence of bound settings and traffic profiles.
        for (int phase = 0; phase < 6; phase++)
        begin
            send_idle_pct  = (phase < 2) ? 30 : (phase < 4) ? 65 : 0;
            recv_idle_pct  = (phase < 2) ? 65 : (phase < 4) ? 30 : 0;
            wait_for_drain = (phase == 4);
            bound_a        = AGE_W'($urandom_range(0, 255));
            case (phase)
                0:
                begin
                    write_bound(REG_AGE_LOW, 8'd0);
                    write_bound(REG_AGE_HIGH, 8'd255);
                end
                1:
                begin
                    write_bound(REG_AGE_LOW, 8'd0);
                    write_bound(REG_AGE_HIGH, 8'd0);
                end
                2:
                begin
                    write_bound(REG_AGE_LOW, 8'd255);
                    write_bound(REG_AGE_HIGH, 8'd255);
                end
                3:
                begin
                    write_bound(REG_AGE_LOW, bound_a);
                    write_bound(REG_AGE_HIGH, AGE_W'($urandom_range(bound_a, 255)));
                end
                4:
                begin
                    write_bound(REG_AGE_LOW, bound_a);
                    write_bound(REG_AGE_HIGH, AGE_W'($urandom_range(0, 255)));
                end
                default:
                begin
                    write_bound(REG_AGE_LOW, AGE_LOW_RESET);
                    write_bound(REG_AGE_HIGH, AGE_HIGH_RESET);
                end
            endcase
            batch_count = 0;
            while (batch_count < BATCH_ITEMS)
            begin
                set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(SLOTS + 1, SLOTS + 3)
                                                      : $urandom_range(1, SLOTS);
                for (int k = 0; k < set_len; k++)
                begin
                    push_rec(random_name(), pick_age(), k == set_len - 1);
                end
                batch_count += set_len;
            end
            wait_idle();
        end

        $display("Sent %0d records in %0d sets and checked %0d slot results.",
                 items_sent, sets_closed, slots_checked);
        $display("Sets with dropped records: %0d; sets with no eligible record: %0d.",
                 overflow_sets, unsorted_sets);
        if (mismatches == 0)
        begin
            $display("filtered_slot_name_sorter regression: pass");
        end
        else
        begin
            $display("filtered_slot_name_sorter regression: fail");
        end
        $finish;
    end

endmodule
